// ----- design/sclp_pkg.sv -----
// shared constants and types of the serial command line parser
package sclp_pkg;

  localparam int unsigned DefLineBufferBytes = 32;

  // longest command text is "led yellow"; later characters never decide a match
  localparam int unsigned MatchChars = 10;
  localparam int unsigned MatchIdxW  = $clog2(MatchChars);

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 3;
  localparam int unsigned LenW  = 5;

  localparam logic [ByteW-1:0] CharCr  = 8'h0D;
  localparam logic [ByteW-1:0] CharLf  = 8'h0A;
  localparam logic [ByteW-1:0] CharBs  = 8'h08;
  localparam logic [ByteW-1:0] CharDel = 8'h7F;

  typedef logic [ByteW-1:0] char_t;

  typedef enum logic [CodeW-1:0] {
    CMD_GREEN    = 3'd0,
    CMD_BLUE     = 3'd1,
    CMD_YELLOW   = 3'd2,
    CMD_RED      = 3'd3,
    CMD_STATUS   = 3'd4,
    CMD_HELP     = 3'd5,
    CMD_UNKNOWN  = 3'd6,
    CMD_TOO_LONG = 3'd7
  } cmd_code_e;

  typedef struct packed {
    logic [LenW-1:0] line_length;
    cmd_code_e       cmd_code;
  } result_t;

endpackage

// ----- design/sclp_match.sv -----
// exact match of the held line against the command set
module sclp_match import sclp_pkg::*; #(
  parameter int unsigned CountW = 5
) (
  input  char_t              chars_i [MatchChars],
  input  logic [CountW-1:0]  count_i,
  output cmd_code_e          cmd_code_o
);

  localparam logic [4*ByteW-1:0]  TxtHelp   = "help";
  localparam logic [6*ByteW-1:0]  TxtStatus = "status";
  localparam logic [7*ByteW-1:0]  TxtRed    = "led red";
  localparam logic [8*ByteW-1:0]  TxtBlue   = "led blue";
  localparam logic [9*ByteW-1:0]  TxtGreen  = "led green";
  localparam logic [10*ByteW-1:0] TxtYellow = "led yellow";

  logic [4*ByteW-1:0]  w4;
  logic [6*ByteW-1:0]  w6;
  logic [7*ByteW-1:0]  w7;
  logic [8*ByteW-1:0]  w8;
  logic [9*ByteW-1:0]  w9;
  logic [10*ByteW-1:0] w10;

  // first character ends up in the top byte, as in a string literal
  assign w4  = {chars_i[0], chars_i[1], chars_i[2], chars_i[3]};
  assign w6  = {w4, chars_i[4], chars_i[5]};
  assign w7  = {w6, chars_i[6]};
  assign w8  = {w7, chars_i[7]};
  assign w9  = {w8, chars_i[8]};
  assign w10 = {w9, chars_i[9]};

  always_comb begin
    cmd_code_o = CMD_UNKNOWN;
    priority if (count_i == CountW'(1)) begin
      priority if (chars_i[0] == "g" || chars_i[0] == "G") cmd_code_o = CMD_GREEN;
      else if (chars_i[0] == "b" || chars_i[0] == "B") cmd_code_o = CMD_BLUE;
      else if (chars_i[0] == "y" || chars_i[0] == "Y") cmd_code_o = CMD_YELLOW;
      else if (chars_i[0] == "r" || chars_i[0] == "R") cmd_code_o = CMD_RED;
      else cmd_code_o = CMD_UNKNOWN;
    end else if (count_i == CountW'(4)) begin
      if (w4 == TxtHelp) cmd_code_o = CMD_HELP;
    end else if (count_i == CountW'(6)) begin
      if (w6 == TxtStatus) cmd_code_o = CMD_STATUS;
    end else if (count_i == CountW'(7)) begin
      if (w7 == TxtRed) cmd_code_o = CMD_RED;
    end else if (count_i == CountW'(8)) begin
      if (w8 == TxtBlue) cmd_code_o = CMD_BLUE;
    end else if (count_i == CountW'(9)) begin
      if (w9 == TxtGreen) cmd_code_o = CMD_GREEN;
    end else if (count_i == CountW'(10)) begin
      if (w10 == TxtYellow) cmd_code_o = CMD_YELLOW;
    end else begin
      cmd_code_o = CMD_UNKNOWN;
    end
  end

endmodule

// ----- design/serial_command_line_parser.sv -----
// top level of the serial command line parser
//
// Takes one received serial byte per item and builds a text line of up to
// LINE_BUFFER_BYTES-1 characters. Backspace and delete drop the last
// character; carriage return or line feed on a non-empty line closes it and
// one result item comes out: the command code (green, blue, yellow, red,
// status, help or unknown) and the line length. A printable or other plain
// byte arriving on a full line is dropped and gives a too long result with
// the line capacity (low 5 bits) as length. Empty line ends and erases give
// nothing. The line state and the first ten characters sit in registers, the
// command compare is a parallel match on them, and its code goes into a
// two-entry output register, so a new byte is taken every cycle unless both
// output entries are full.
module serial_command_line_parser import sclp_pkg::*; #(
  parameter int unsigned LINE_BUFFER_BYTES = DefLineBufferBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // command results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [2:0] cmd_code, [7:3] line_length
);

  localparam int unsigned CountW = $clog2(LINE_BUFFER_BYTES);
  localparam logic [CountW-1:0] LineCap = CountW'(LINE_BUFFER_BYTES - 1);

  // line state
  logic [CountW-1:0] count_q, count_d;
  char_t             chars_q [MatchChars];

  // output register and skid entry
  logic    out_valid_q, out_valid_d;
  result_t out_data_q, out_data_d;
  logic    skid_valid_q, skid_valid_d;
  result_t skid_data_q, skid_data_d;

  logic      in_acc;
  logic      out_pop;
  logic      is_end, is_erase;
  logic      push;
  logic      store_en;
  result_t   res;
  cmd_code_e match_code;

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_pop       = out_valid_q && m_axis_tready;

  assign is_end   = (s_axis_tdata == CharCr) || (s_axis_tdata == CharLf);
  assign is_erase = (s_axis_tdata == CharBs) || (s_axis_tdata == CharDel);

  sclp_match #(
    .CountW (CountW)
  ) u_match (
    .chars_i    (chars_q),
    .count_i    (count_q),
    .cmd_code_o (match_code)
  );

  // line update and result selection for the byte on the input
  always_comb begin
    count_d  = count_q;
    push     = 1'b0;
    store_en = 1'b0;
    res.cmd_code    = match_code;
    res.line_length = LenW'(count_q);
    if (in_acc) begin
      priority if (is_end) begin
        // close a non-empty line, ignore an empty one
        if (count_q != '0) begin
          push    = 1'b1;
          count_d = '0;
        end
      end else if (is_erase) begin
        if (count_q != '0) count_d = count_q - CountW'(1);
      end else if (count_q < LineCap) begin
        store_en = (count_q < CountW'(MatchChars));
        count_d  = count_q + CountW'(1);
      end else begin
        // full line: drop the byte and report too long
        push            = 1'b1;
        count_d         = '0;
        res.cmd_code    = CMD_TOO_LONG;
        res.line_length = LenW'(LineCap);
      end
    end
  end

  // two-entry output queue
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // input is stalled here, only drain
      if (out_pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || out_pop) begin
        out_data_d  = res;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
    if (store_en) chars_q[count_q[MatchIdxW-1:0]] <= s_axis_tdata;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LineCap)
    else $error("line count above capacity");

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output empty");

  a_too_long_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.cmd_code == CMD_TOO_LONG)
      |-> out_data_q.line_length == LenW'(LineCap))
    else $error("too long result with wrong length");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> count_q == '0)
    else $error("line not cleared after result");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push)
    else $error("result pushed while both entries full");
`endif

endmodule

// ----- verif/serial_command_line_parser_tb.sv -----
// testbench for the serial command line parser: random and directed byte streams, scoreboard check
module serial_command_line_parser_tb import sclp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineCap = DefLineBufferBytes - 1;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [2:0] cmd_code, [7:3] line_length

  // idling on both sides; switched off for one long stretch
  bit idle_on = 1'b1;

  string cmd_texts[14] = '{"g", "G", "led green", "b", "B", "led blue",
                           "y", "Y", "led yellow", "r", "R", "led red",
                           "status", "help"};

  // line predictor plus the queue of command results still owed by the block
  class line_scoreboard;
    char_t       line_chars[LineCap];
    int unsigned char_cnt;
    result_t     owed_q[$];
    int unsigned errors;
    int unsigned bytes_used;
    int unsigned results_seen;
    int unsigned code_hits[8];

    function new();
      char_cnt = 0;
      errors = 0;
      bytes_used = 0;
      results_seen = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
    endfunction

    function bit line_is(string s);
      if (s.len() != char_cnt) return 1'b0;
      for (int i = 0; i < s.len(); i++) begin
        if (line_chars[i] != char_t'(s[i])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function cmd_code_e classify();
      if (line_is("g") || line_is("G") || line_is("led green")) return CMD_GREEN;
      if (line_is("b") || line_is("B") || line_is("led blue")) return CMD_BLUE;
      if (line_is("y") || line_is("Y") || line_is("led yellow")) return CMD_YELLOW;
      if (line_is("r") || line_is("R") || line_is("led red")) return CMD_RED;
      if (line_is("status")) return CMD_STATUS;
      if (line_is("help")) return CMD_HELP;
      return CMD_UNKNOWN;
    endfunction

    // one accepted input byte
    function void note_byte(char_t b);
      result_t r;
      if (b == CharCr || b == CharLf) begin
        // line end on an empty line does nothing
        if (char_cnt > 0) begin
          r.cmd_code = classify();
          r.line_length = LenW'(char_cnt);
          owed_q.push_back(r);
          char_cnt = 0;
          bytes_used++;
        end
      end else if (b == CharBs || b == CharDel) begin
        if (char_cnt > 0) begin
          char_cnt--;
          bytes_used++;
        end
      end else if (char_cnt < LineCap) begin
        line_chars[char_cnt] = b;
        char_cnt++;
        bytes_used++;
      end else begin
        // full line: byte dropped, too long reported with the capacity
        r.cmd_code = CMD_TOO_LONG;
        r.line_length = LenW'(LineCap);
        owed_q.push_back(r);
        char_cnt = 0;
        bytes_used++;
      end
    endfunction

    // one accepted result item
    function void check_result(logic [7:0] d);
      result_t got;
      result_t want;
      got = result_t'(d);
      if (owed_q.size() == 0) begin
        $error("unexpected result item: cmd_code %0d line_length %0d",
               got.cmd_code, got.line_length);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      results_seen++;
      code_hits[want.cmd_code]++;
      if (got.cmd_code !== want.cmd_code) begin
        $error("cmd_code: expected %0d, actual %0d", want.cmd_code, got.cmd_code);
        errors++;
      end
      if (got.line_length !== want.line_length) begin
        $error("line_length: expected %0d, actual %0d", want.line_length, got.line_length);
        errors++;
      end
    endfunction
  endclass

  line_scoreboard sb = new();

  serial_command_line_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // result side stalls at random
  always @(negedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= 16);
    end
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input char_t b);
    while (idle_on && $urandom_range(99, 0) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic char_t plain_byte();
    char_t b;
    do b = char_t'($urandom_range(255, 0));
    while (b == CharCr || b == CharLf || b == CharBs || b == CharDel);
    return b;
  endfunction

  function automatic char_t line_end();
    return $urandom_range(1, 0) ? CharCr : CharLf;
  endfunction

  function automatic char_t erase_byte();
    return $urandom_range(1, 0) ? CharBs : CharDel;
  endfunction

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(char_t'(s[i]));
  endtask

  // one randomly shaped chunk of traffic
  task automatic random_chunk();
    int    kind;
    int    mut;
    int    stop;
    int    n;
    string cmd;
    char_t b;
    kind = $urandom_range(99, 0);
    if (kind < 50) begin
      // command text, sometimes with a fixed typo, a bad char, a cut or an extra char
      cmd = cmd_texts[$urandom_range(13, 0)];
      mut = ($urandom_range(4, 0) == 0) ? $urandom_range(cmd.len() - 1, 0) : -1;
      stop = ($urandom_range(9, 0) == 0) ? cmd.len() - 1 : cmd.len();
      if ($urandom_range(3, 0) == 0) begin
        send_byte(plain_byte());
        send_byte(erase_byte());
      end
      for (int i = 0; i < stop; i++) begin
        b = (i == mut) ? plain_byte() : char_t'(cmd[i]);
        send_byte(b);
      end
      if ($urandom_range(9, 0) == 0) send_byte(plain_byte());
      send_byte(line_end());
    end else if (kind < 62) begin
      // fill the line to capacity, then overflow it or close it
      for (int i = 0; i < LineCap; i++) send_byte(plain_byte());
      n = $urandom_range(3, 0);
      if (n < 2) begin
        send_byte(plain_byte());
        if (n == 0) send_byte(line_end());
      end else if (n == 2) begin
        send_byte(erase_byte());
        send_byte(line_end());
      end else begin
        send_byte(line_end());
      end
    end else if (kind < 82) begin
      // random content of any byte value
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) send_byte(char_t'($urandom_range(255, 0)));
      send_byte(line_end());
    end else begin
      // noise
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) send_byte(char_t'($urandom_range(255, 0)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty line end and erase, short commands, erase, byte extremes
    send_byte(CharCr);
    send_byte(CharLf);
    send_byte(CharBs);
    send_byte(CharDel);
    send_text("g");  send_byte(CharCr);
    send_text("B");  send_byte(CharLf);
    send_text("y");  send_byte(CharCr);
    send_text("R");  send_byte(CharCr);
    send_text("x");  send_byte(CharBs); send_text("r"); send_byte(CharLf);
    send_byte(8'h00); send_byte(CharLf);
    send_byte(8'hFF); send_byte(CharCr);

    // random traffic, with a long stretch free of idling in the middle
    while (sb.bytes_used < 2000) begin
      idle_on = !(sb.bytes_used >= 700 && sb.bytes_used < 1100);
      random_chunk();
    end
    idle_on = 1'b1;
    s_axis_tvalid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d effective input bytes and %0d results", sb.bytes_used,
             sb.results_seen);
    $display({"per code: green %0d blue %0d yellow %0d red %0d status %0d help %0d",
              " unknown %0d too long %0d"},
             sb.code_hits[0], sb.code_hits[1], sb.code_hits[2], sb.code_hits[3],
             sb.code_hits[4], sb.code_hits[5], sb.code_hits[6], sb.code_hits[7]);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

endmodule
